>>> hdl/mmrh_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and lane tables for the rolling hash matcher.
// No dependencies; imported by every module of the block.
package mmrh_pkg;

  localparam int TBL_LANES = 10;

  // Input action codes
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_PAT   = 2'd1;
  localparam logic [1:0] ACT_FILL  = 2'd2;
  localparam logic [1:0] ACT_ROLL  = 2'd3;

  // Writeback destinations of a multiply-modulo operation
  localparam logic [1:0] KIND_PAT  = 2'd0;
  localparam logic [1:0] KIND_WIN  = 2'd1;
  localparam logic [1:0] KIND_POW  = 2'd2;
  localparam logic [1:0] KIND_DROP = 2'd3;

  localparam logic [14:0] BASE_TBL [TBL_LANES] = '{
    15'd101, 15'd12343, 15'd11311, 15'd113, 15'd12161,
    15'd43, 15'd12323, 15'd103, 15'd12203, 15'd11411
  };

  localparam logic [14:0] MOD_TBL [TBL_LANES] = '{
    15'd31601, 15'd31543, 15'd31397, 15'd31327, 15'd31081,
    15'd30817, 15'd30577, 15'd30497, 15'd30271, 15'd30253
  };

  // floor(2^31 / modulus): quotient estimate is off by at most one
  localparam logic [16:0] RECIP_TBL [TBL_LANES] = '{
    17'(64'd2147483648 / 64'd31601), 17'(64'd2147483648 / 64'd31543),
    17'(64'd2147483648 / 64'd31397), 17'(64'd2147483648 / 64'd31327),
    17'(64'd2147483648 / 64'd31081), 17'(64'd2147483648 / 64'd30817),
    17'(64'd2147483648 / 64'd30577), 17'(64'd2147483648 / 64'd30497),
    17'(64'd2147483648 / 64'd30271), 17'(64'd2147483648 / 64'd30253)
  };

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  lane;
    logic [14:0] carry;   // window hash riding along with a drop term
  } mm_tag_t;

  typedef struct packed {
    logic [14:0] a;
    logic [14:0] b;
    logic [7:0]  c;
    mm_tag_t     tag;
  } mm_op_t;

  typedef struct packed {
    logic [14:0] value;
    mm_tag_t     tag;
  } mm_res_t;

endpackage

>>> hdl/mmrh_mulmod.sv
`timescale 1ns / 1ps
// Shared four-stage (a*b + c) mod m unit, m picked per lane from the tables.
// Depends on mmrh_pkg.
module mmrh_mulmod import mmrh_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    op_valid,
  input  mm_op_t  op,
  output logic    res_valid,
  output mm_res_t res,
  output logic    busy
);

  logic        va_r, vb_r, vc_r, vd_r;
  mm_tag_t     tag_a_r, tag_b_r, tag_c_r, tag_d_r;
  logic [30:0] p_a_r, p_b_r;
  logic [16:0] q_b_r;
  logic [15:0] t_c_r;
  logic [14:0] r_d_r;

  logic [29:0] ab;
  logic [30:0] p_nxt;
  logic [47:0] pr;
  logic [31:0] qm;
  logic [31:0] t_nxt;
  logic [14:0] m_c, m_d;
  logic [15:0] r_nxt;

  assign ab    = op.a * op.b;
  assign p_nxt = {1'b0, ab} + {23'b0, op.c};
  assign pr    = 48'(p_a_r) * 48'(RECIP_TBL[tag_a_r.lane]);
  assign m_c   = MOD_TBL[tag_b_r.lane];
  assign qm    = 32'(q_b_r) * 32'(m_c);
  assign t_nxt = 32'(p_b_r) - qm;
  assign m_d   = MOD_TBL[tag_c_r.lane];
  // remainder estimate is below 2m: one conditional subtract
  assign r_nxt = (t_c_r >= {1'b0, m_d}) ? t_c_r - {1'b0, m_d} : t_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      va_r <= op_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    p_a_r   <= p_nxt;
    tag_a_r <= op.tag;
    p_b_r   <= p_a_r;
    q_b_r   <= pr[47:31];
    tag_b_r <= tag_a_r;
    t_c_r   <= t_nxt[15:0];
    tag_c_r <= tag_b_r;
    r_d_r   <= r_nxt[14:0];
    tag_d_r <= tag_c_r;
  end

  assign res_valid = vd_r;
  assign res.value = r_d_r;
  assign res.tag   = tag_d_r;
  assign busy      = va_r | vb_r | vc_r | vd_r;

endmodule

>>> hdl/mmrh_bank.sv
`timescale 1ns / 1ps
// Per-lane pattern hash, window hash and leading power registers,
// result writeback and the lane compare. Depends on mmrh_pkg.
module mmrh_bank import mmrh_pkg::*; #(
  parameter int LANES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clear,
  input  logic [3:0]  rd_lane,
  output logic [14:0] rd_pat,
  output logic [14:0] rd_win,
  output logic [14:0] rd_pow,
  input  logic        wb_valid,
  input  mm_res_t     wb,
  input  logic [3:0]  lanes_eff,
  output logic        match
);

  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

  logic [14:0] pat_r [LANES];
  logic [14:0] win_r [LANES];
  logic [14:0] pow_r [LANES];

  logic [LW-1:0] rd_idx, wb_idx;
  logic [14:0]   wb_mod;
  logic [15:0]   diff;
  logic [15:0]   diff_fix;
  logic [14:0]   win_new;
  logic [LANES-1:0] eq_vec;

  assign rd_idx = rd_lane[LW-1:0];
  assign wb_idx = wb.tag.lane[LW-1:0];
  assign rd_pat = pat_r[rd_idx];
  assign rd_win = win_r[rd_idx];
  assign rd_pow = pow_r[rd_idx];

  // drop term: window minus leaving byte's weight, wrapped into [0, m)
  assign wb_mod   = MOD_TBL[wb.tag.lane];
  assign diff     = {1'b0, wb.tag.carry} - {1'b0, wb.value};
  assign diff_fix = diff[15] ? diff + {1'b0, wb_mod} : diff;
  assign win_new  = (wb.tag.kind == KIND_DROP) ? diff_fix[14:0] : wb.value;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int i = 0; i < LANES; i++) begin
        pat_r[i] <= 15'd0;
        win_r[i] <= 15'd0;
        pow_r[i] <= 15'd1;
      end
    end else if (wb_valid) begin
      case (wb.tag.kind)
        KIND_PAT: pat_r[wb_idx] <= wb.value;
        KIND_POW: pow_r[wb_idx] <= wb.value;
        KIND_WIN, KIND_DROP: win_r[wb_idx] <= win_new;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      eq_vec[i] = (pat_r[i] == win_r[i]) || (4'(i) >= lanes_eff);
    end
  end

  assign match = &eq_vec;

endmodule

>>> hdl/multi_modulus_rolling_hash_matcher.sv
`timescale 1ns / 1ps
// Rabin-Karp matcher with up to LANES hash lanes; every input beat returns
// one match beat. One pipelined multiply-modulo unit (four stages) is fed
// one lane per cycle: a clear makes no pass over the lanes, a window fill or
// the first pattern byte makes one pass, a roll or any later pattern byte two
// passes, each waiting for its last writeback. The input is not ready
// while an item is at work; a finished match may wait in the output register.
module multi_modulus_rolling_hash_matcher import mmrh_pkg::*; #(
  parameter int LANES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] head_byte, [15:8] tail_byte
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] match, [7:1] zero
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata   // [3:0] lanes_in_use, [7:4] unused
);

  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam logic [LW-1:0] LAST_LANE = LW'(LANES - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    action_r;
  logic [7:0]    head_r, tail_r;
  logic          phase_r, phase_nxt;
  logic [LW-1:0] lane_r, lane_nxt;
  logic          started_r;
  logic [3:0]    lanes_r;
  logic          out_valid_r;
  logic          out_match_r;

  logic        in_beat, clear, load_out, second_pass;
  logic [3:0]  lane4, lanes_eff;
  logic [14:0] rd_pat, rd_win, rd_pow, base;
  logic        op_valid, res_valid, busy, match;
  mm_op_t      op;
  mm_res_t     res;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign clear      = in_beat && (in_tuser == ACT_CLEAR);
  assign cfg_tready = 1'b1;
  assign lane4      = 4'(lane_r);
  assign base       = BASE_TBL[lane4];
  assign load_out   = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign second_pass = (action_r == ACT_ROLL) || ((action_r == ACT_PAT) && started_r);

  assign lanes_eff = (lanes_r == 4'd0) ? 4'd1 :
                     (lanes_r > 4'(LANES)) ? 4'(LANES) : lanes_r;

  // Build the operation for the current lane and pass
  always_comb begin
    op.a         = rd_win;
    op.b         = base;
    op.c         = head_r;
    op.tag.kind  = KIND_WIN;
    op.tag.lane  = lane4;
    op.tag.carry = rd_win;
    case (action_r)
      ACT_PAT: begin
        if (!phase_r) begin
          op.a        = rd_pat;
          op.tag.kind = KIND_PAT;
        end else begin
          op.a        = rd_pow;
          op.c        = 8'd0;
          op.tag.kind = KIND_POW;
        end
      end
      ACT_ROLL: begin
        if (!phase_r) begin
          op.a        = rd_pow;
          op.b        = {7'd0, tail_r};
          op.c        = 8'd0;
          op.tag.kind = KIND_DROP;
        end
      end
      default: ;
    endcase
  end

  assign op_valid = (state_r == ST_ISSUE);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    lane_nxt  = lane_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          phase_nxt = 1'b0;
          lane_nxt  = '0;
          state_nxt = (in_tuser == ACT_CLEAR) ? ST_DONE : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (lane_r == LAST_LANE) begin
          state_nxt = ST_DRAIN;
        end else begin
          lane_nxt = lane_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        // wait for the last writeback before the next pass or the compare
        if (!busy) begin
          if (!phase_r && second_pass) begin
            phase_nxt = 1'b1;
            lane_nxt  = '0;
            state_nxt = ST_ISSUE;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 1'b0;
      lane_r      <= '0;
      started_r   <= 1'b0;
      lanes_r     <= 4'd10;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      lane_r  <= lane_nxt;
      if (cfg_tvalid && cfg_tready) lanes_r <= cfg_tdata[3:0];
      if (clear) begin
        started_r <= 1'b0;
      end else if (load_out && (action_r == ACT_PAT)) begin
        started_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      action_r <= in_tuser;
      head_r   <= in_tdata[7:0];
      tail_r   <= in_tdata[15:8];
    end
    if (load_out) out_match_r <= match;
  end

  mmrh_mulmod u_mulmod (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op        (op),
    .res_valid (res_valid),
    .res       (res),
    .busy      (busy)
  );

  mmrh_bank #(
    .LANES (LANES)
  ) u_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (clear),
    .rd_lane   (lane4),
    .rd_pat    (rd_pat),
    .rd_win    (rd_win),
    .rd_pow    (rd_pow),
    .wb_valid  (res_valid),
    .wb        (res),
    .lanes_eff (lanes_eff),
    .match     (match)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_match_r};

`ifndef ASSERT_OFF
  a_no_accept_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready)
    else $error("input ready while lane operations in flight");

  a_wb_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (state_r == ST_ISSUE || state_r == ST_DRAIN))
    else $error("writeback outside of lane passes");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == ST_DONE)
    else $error("result beat not produced by the compare step");

  a_lane_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ISSUE |-> lane_r <= LAST_LANE)
    else $error("issue lane beyond lane count");
`endif

endmodule

>>> tb/tb_multi_modulus_rolling_hash_matcher.sv
`timescale 1ns / 1ps
// Self-checking bench for the rolling hash matcher: directed rows, then random
// search runs and single beats per lane count. Depends on mmrh_pkg, top level.
module tb_multi_modulus_rolling_hash_matcher import mmrh_pkg::*;;

  localparam int NUM_LANES = 10;
  localparam int DRAIN_CYCLES = 2 * NUM_LANES + 20;
  localparam int ITEM_TARGET = 1050;
  localparam int NUM_PHASES = 6;
  localparam int HOLD_AT_RESULT = 300;
  localparam int HOLD_CYCLES = 400;

  localparam int unsigned HASH_BASE [NUM_LANES] = '{
    101, 12343, 11311, 113, 12161, 43, 12323, 103, 12203, 11411
  };
  localparam int unsigned HASH_MOD [NUM_LANES] = '{
    31601, 31543, 31397, 31327, 31081, 30817, 30577, 30497, 30271, 30253
  };

  typedef struct {
    logic [1:0] act;
    logic [7:0] head;
    logic [7:0] tail;
    int         want;   // -1: take the predicted match
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] head_byte, [15:8] tail_byte
  logic [1:0]  in_tuser;   // [1:0] action
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [0] match, [7:1] zero
  logic        cfg_tvalid;
  logic        cfg_tready;
  logic [7:0]  cfg_tdata;  // [3:0] lanes_in_use, [7:4] unused

  multi_modulus_rolling_hash_matcher #(.LANES(NUM_LANES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  // Predicted state of every lane
  logic [14:0] pat_hash [NUM_LANES];
  logic [14:0] win_hash [NUM_LANES];
  logic [14:0] lead_pow [NUM_LANES];
  logic        pat_begun;
  logic [3:0]  lanes_cfg;

  logic      match_q [$];
  stim_row_t dir_tbl [$];

  int err_cnt = 0;
  int mism_cnt = 0;
  int n_items = 0;
  int n_results = 0;
  int n_matches = 0;
  int n_cfg = 0;
  int send_quiet = 0;
  int recv_quiet = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #(5_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void clear_hashes();
    for (int i = 0; i < NUM_LANES; i++) begin
      pat_hash[i] = '0;
      win_hash[i] = '0;
      lead_pow[i] = 15'd1;
    end
    pat_begun = 1'b0;
  endfunction

  function automatic void add_row(logic [1:0] act, logic [7:0] head, logic [7:0] tail,
                                  int want);
    stim_row_t row;
    row = '{act, head, tail, want};
    dir_tbl = {dir_tbl, row};
  endfunction

  // Apply one input beat to the lane state and return the expected match
  function automatic logic advance_hashes(logic [1:0] act, logic [7:0] head,
                                          logic [7:0] tail);
    int unsigned b, m, drop, x;
    int n;
    logic eq;
    if (act == ACT_CLEAR) begin
      clear_hashes();
    end else begin
      for (int i = 0; i < NUM_LANES; i++) begin
        b = HASH_BASE[i];
        m = HASH_MOD[i];
        case (act)
          ACT_PAT: begin
            pat_hash[i] = 15'((pat_hash[i] * b + head) % m);
            if (pat_begun) lead_pow[i] = 15'((lead_pow[i] * b) % m);
          end
          ACT_FILL: begin
            win_hash[i] = 15'((win_hash[i] * b + head) % m);
          end
          default: begin
            drop = (lead_pow[i] * tail) % m;
            x = (win_hash[i] % m + m - drop) % m;
            win_hash[i] = 15'((x * b + head) % m);
          end
        endcase
      end
      if (act == ACT_PAT) pat_begun = 1'b1;
    end
    n = (lanes_cfg == 0) ? 1 : (lanes_cfg > NUM_LANES) ? NUM_LANES : int'(lanes_cfg);
    eq = 1'b1;
    for (int i = 0; i < n; i++)
      if (pat_hash[i] != win_hash[i]) eq = 1'b0;
    return eq;
  endfunction

  // Idle length before the next beat, with occasional back-to-back stretches
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // Called and left at a falling edge
  task automatic send_item(logic [1:0] act, logic [7:0] head, logic [7:0] tail, int want);
    int gap;
    logic pred;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {tail, head};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = advance_hashes(act, head, tail);
    match_q = {match_q, (want < 0) ? pred : logic'(want)};
    n_items++;
    @(negedge clk);
  endtask

  task automatic write_lanes(logic [3:0] lanes);
    in_tvalid <= 1'b0;
    while (match_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= {4'($urandom), lanes};
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    lanes_cfg = lanes;
    n_cfg++;
    @(negedge clk);
    cfg_tvalid <= 1'b0;
  endtask

  // Clear, load a pattern, fill the window, then roll across a text that
  // sometimes carries the pattern; now and then a wrong leaving byte
  task automatic send_search_run();
    logic [7:0] pat [$];
    logic [7:0] txt [$];
    logic [7:0] sym0, sym1;
    int plen, tlen, k;
    bit narrow;
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
    tlen = plen + $urandom_range(0, 24);
    narrow = ($urandom_range(0, 2) != 0);
    sym0 = 8'($urandom);
    sym1 = 8'($urandom);
    for (k = 0; k < plen; k++)
      pat = {pat, narrow ? ($urandom_range(0, 1) ? sym1 : sym0) : 8'($urandom)};
    k = 0;
    while (k < tlen) begin
      if ($urandom_range(0, 3) == 0 && k + plen <= tlen) begin
        foreach (pat[j]) txt = {txt, pat[j]};
        k += plen;
      end else begin
        txt = {txt, narrow ? ($urandom_range(0, 1) ? sym1 : sym0) : 8'($urandom)};
        k++;
      end
    end
    send_item(ACT_CLEAR, 8'($urandom), 8'($urandom), -1);
    foreach (pat[j]) send_item(ACT_PAT, pat[j], 8'($urandom), -1);
    for (k = 0; k < plen; k++) send_item(ACT_FILL, txt[k], 8'($urandom), -1);
    for (k = plen; k < txt.size(); k++)
      send_item(ACT_ROLL, txt[k],
                ($urandom_range(0, 15) == 0) ? 8'($urandom) : txt[k - plen], -1);
  endtask

  // Result side: random stalls plus one long hold-off to back up the block
  initial begin
    bit held;
    int gap;
    logic want;
    held = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    @(negedge clk);
    forever begin
      if (!held && n_results == HOLD_AT_RESULT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = draw_gap(recv_quiet);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      n_results++;
      if (out_tdata[0]) n_matches++;
      if (match_q.size() == 0) begin
        err_cnt++;
        mism_cnt++;
        if (mism_cnt <= 10)
          $display("ERROR: result beat %0d (tdata=%h) with nothing expected",
                   n_results, out_tdata);
      end else begin
        want = match_q.pop_front();
        if (out_tdata !== {7'd0, want}) begin
          err_cnt++;
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("MISMATCH result %0d: match expected %0b, tdata got %h",
                     n_results, want, out_tdata);
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    logic [3:0] phase_lanes [NUM_PHASES];
    int dir_count, budget, stop_at;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= ACT_CLEAR;
    cfg_tvalid <= 1'b0;
    cfg_tdata  <= '0;
    lanes_cfg = 4'd10;
    clear_hashes();

    // Directed rows: reset state, byte extremes, every action, broken rolls
    add_row(ACT_FILL,  8'h00, 8'hFF, 1);
    add_row(ACT_PAT,   8'hFF, 8'h00, 0);
    add_row(ACT_FILL,  8'hFF, 8'h00, 1);
    add_row(ACT_CLEAR, 8'h00, 8'h00, 1);
    add_row(ACT_PAT,   8'h00, 8'hFF, 1);
    add_row(ACT_PAT,   8'hFF, 8'hFF, -1);
    add_row(ACT_FILL,  8'h00, 8'h00, -1);
    add_row(ACT_FILL,  8'hFF, 8'hFF, -1);
    add_row(ACT_ROLL,  8'h00, 8'h00, -1);
    add_row(ACT_ROLL,  8'hFF, 8'hFF, -1);
    add_row(ACT_ROLL,  8'hAA, 8'h00, -1);
    add_row(ACT_ROLL,  8'h55, 8'h5A, -1);
    add_row(ACT_CLEAR, 8'hFF, 8'hFF, 1);
    add_row(ACT_ROLL,  8'h00, 8'hFF, -1);
    add_row(ACT_CLEAR, 8'h81, 8'h7E, 1);
    add_row(ACT_PAT,   8'h41, 8'h00, -1);
    add_row(ACT_PAT,   8'h42, 8'h00, -1);
    add_row(ACT_PAT,   8'h43, 8'h00, -1);
    add_row(ACT_FILL,  8'h58, 8'hC3, -1);
    add_row(ACT_FILL,  8'h41, 8'h3C, -1);
    add_row(ACT_FILL,  8'h42, 8'h00, -1);
    add_row(ACT_ROLL,  8'h43, 8'h58, -1);
    add_row(ACT_ROLL,  8'h41, 8'h41, -1);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tbl[r]) send_item(dir_tbl[r].act, dir_tbl[r].head, dir_tbl[r].tail,
                                   dir_tbl[r].want);
    dir_count = n_items;

    // Lane counts per phase: low extreme, zero, above range, full, then random
    phase_lanes[0] = 4'd1;
    phase_lanes[1] = 4'd0;
    phase_lanes[2] = 4'd15;
    phase_lanes[3] = 4'd10;
    phase_lanes[4] = 4'($urandom_range(2, 9));
    phase_lanes[5] = 4'($urandom_range(0, 15));
    budget = (ITEM_TARGET - dir_count) / NUM_PHASES;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_lanes(phase_lanes[p]);
      stop_at = dir_count + (p + 1) * budget;
      while (n_items < stop_at) begin
        if ($urandom_range(0, 99) < 15)
          send_item(2'($urandom), 8'($urandom), 8'($urandom), -1);
        else
          send_search_run();
      end
    end
    in_tvalid <= 1'b0;

    while (match_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Summary: %0d input beats, %0d results checked, %0d of them matches",
             n_items, n_results, n_matches);
    $display("Summary: %0d lane count settings, %0d mismatches", n_cfg, mism_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/mmrh_pkg.sv
hdl/mmrh_mulmod.sv
hdl/mmrh_bank.sv
hdl/multi_modulus_rolling_hash_matcher.sv
tb/tb_multi_modulus_rolling_hash_matcher.sv
